>>> sv/lru_pfr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page-frame replacement package
// Shared types and fixed field widths for the controller and the datapath.
// ----------------------------------------------------------------------------
package lru_pfr_pkg;

   localparam int REQ_PAGE_W     = 16;
   localparam int FRAME_INDEX_W  = 3;
   localparam int EVICTED_PAGE_W = 16;
   localparam int FAULT_W        = 32;
   localparam int CSR_W          = 4;

   localparam logic [CSR_W-1:0] FRAME_COUNT_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_issue;
      logic out_free;
   } ctl_status_type;

endpackage

>>> sv/lru_page_frame_replacement.sv
// ----------------------------------------------------------------------------
// LRU page-frame replacement
// Fully associative page frames with last-use stamps and a saturating fault
// counter.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  page_number
//   rsp_      out        rsp_valid / rsp_stall  hit, frame_index, evicted_valid,
//                                               evicted_page, fault_count
//   csr_      in         csr_write              frame_count
//
// A transaction, n being the number of frames in use, is accepted, then the
// frames are read one per cycle from the frame memory port, the last compare
// is made and a final step updates the frame and loads the result.
// Reset is synchronous; it empties all frames and clears both counters.
// A stalled result holds the update step; the next transaction is not
// accepted until the result register can load.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement import lru_pfr_pkg::*; #(
   parameter int FRAMES     = 8,
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [REQ_PAGE_W-1:0]     req_page_number,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic [FRAME_INDEX_W-1:0]  rsp_frame_index,
   output logic                      rsp_evicted_valid,
   output logic [EVICTED_PAGE_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]        rsp_fault_count,
   input  logic                      csr_write,
   input  logic [CSR_W-1:0]          csr_frame_count
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   lru_pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lru_pfr_dp #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_frame_count   (csr_frame_count),
      .req_page_number   (req_page_number),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

`ifndef ASSERT_OFF
   // The block is busy for the whole scan after taking a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted again right after a transaction");

   // A hit never evicts a page.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted_valid))
      else $error("hit reported together with an eviction");

   // Without an eviction the evicted page reads as zero.
   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without an eviction");

   // The fault total of a hit equals that of the previous result.
   a_hit_faults: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_hit && $past(rsp_valid, 1) == 1'b0
         |-> rsp_fault_count == $past(rsp_fault_count, 1))
      else $error("fault count changed on a hit");
`endif

endmodule

>>> sv/lru_pfr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page-frame replacement controller
// Sequences the frame scan, the final compare and the frame update.
// ----------------------------------------------------------------------------
module lru_pfr_ctrl import lru_pfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_UPDATE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> sv/lru_pfr_dp.sv
// ----------------------------------------------------------------------------
// LRU page-frame replacement datapath
// Frame memories, scan accumulators, counters and the result register.
// ----------------------------------------------------------------------------
module lru_pfr_dp import lru_pfr_pkg::*; #(
   parameter int FRAMES     = 8,
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_cmd_type               cmd,
   output ctl_status_type            status,
   input  logic                      csr_write,
   input  logic [CSR_W-1:0]          csr_frame_count,
   input  logic [REQ_PAGE_W-1:0]     req_page_number,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic [FRAME_INDEX_W-1:0]  rsp_frame_index,
   output logic                      rsp_evicted_valid,
   output logic [EVICTED_PAGE_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]        rsp_fault_count
);

   localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam logic [IDX_BITS-1:0] LAST_FRAME = IDX_BITS'(FRAMES - 1);
   localparam logic [7:0] FRAMES_W8 = 8'(FRAMES);

   // Frame storage.
   logic [PAGE_BITS-1:0]  page_mem [FRAMES];
   logic [STAMP_BITS-1:0] stamp_mem [FRAMES];
   logic [FRAMES-1:0]     valid_ff, valid_in;

   logic [CSR_W-1:0]      csr_ff, csr_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [IDX_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic [IDX_BITS-1:0]   cmp_idx_ff;
   logic                  cmp_en_ff;
   logic [PAGE_BITS-1:0]  page_rd_ff;
   logic [STAMP_BITS-1:0] stamp_rd_ff;

   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic                  empty_ff, empty_in;
   logic [IDX_BITS-1:0]   empty_idx_ff, empty_idx_in;
   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [PAGE_BITS-1:0]  best_page_ff, best_page_in;

   logic [STAMP_BITS-1:0] use_ctr_ff, use_ctr_in;
   logic [FAULT_W-1:0]    fault_ff, fault_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff;
   logic [FRAME_INDEX_W-1:0]  rsp_index_ff;
   logic                      rsp_ev_valid_ff;
   logic [EVICTED_PAGE_W-1:0] rsp_ev_page_ff;
   logic [FAULT_W-1:0]        rsp_fault_ff;

   logic [7:0]                  fc_ext;
   logic [IDX_BITS-1:0]         last_idx;
   logic [PAGE_BITS+REQ_PAGE_W-1:0] req_ext;
   logic                        cur_valid;
   logic                        is_match;
   logic [IDX_BITS-1:0]         pos;
   logic                        miss;
   logic                        evict;
   logic [IDX_BITS+FRAME_INDEX_W-1:0] pos_ext;
   logic [PAGE_BITS+EVICTED_PAGE_W-1:0] ev_ext;

   // Number of frames in use, clamped to one at the bottom and FRAMES at the top.
   always_comb begin
      fc_ext = 8'(csr_ff);
      if (fc_ext == 8'd0) begin
         last_idx = '0;
      end else if (fc_ext >= FRAMES_W8) begin
         last_idx = LAST_FRAME;
      end else begin
         last_idx = IDX_BITS'(fc_ext - 8'd1);
      end
   end

   assign req_ext   = (PAGE_BITS + REQ_PAGE_W)'(req_page_number);
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign is_match  = cur_valid && (page_rd_ff == page_ff);

   assign pos   = found_ff ? hit_idx_ff : (empty_ff ? empty_idx_ff : best_idx_ff);
   assign miss  = !found_ff;
   assign evict = miss && !empty_ff;

   assign pos_ext = (IDX_BITS + FRAME_INDEX_W)'(pos);
   assign ev_ext  = (PAGE_BITS + EVICTED_PAGE_W)'(best_page_ff);

   assign status.last_issue = (scan_idx_ff == last_idx);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Frame memories: one registered read port for the scan, one write port.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         page_rd_ff  <= page_mem[scan_idx_ff];
         stamp_rd_ff <= stamp_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         page_mem[pos]  <= page_ff;
         stamp_mem[pos] <= use_ctr_ff;
      end
   end

   always_comb begin
      csr_in       = csr_write ? csr_frame_count : csr_ff;
      page_in      = cmd.start ? req_ext[PAGE_BITS-1:0] : page_ff;
      scan_idx_in  = scan_idx_ff;
      if (cmd.start) begin
         scan_idx_in = '0;
      end else if (cmd.issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in[pos] = 1'b1;
      end

      use_ctr_in = use_ctr_ff;
      fault_in   = fault_ff;
      if (cmd.commit) begin
         if (use_ctr_ff != '1) begin
            use_ctr_in = use_ctr_ff + 1'b1;
         end
         if (miss && (fault_ff != '1)) begin
            fault_in = fault_ff + 1'b1;
         end
      end
   end

   // Scan accumulators: first match, first empty frame and oldest stamp.
   always_comb begin
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      empty_in      = empty_ff;
      empty_idx_in  = empty_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      best_page_in  = best_page_ff;
      if (cmd.start) begin
         found_in = 1'b0;
         empty_in = 1'b0;
      end else if (cmp_en_ff) begin
         if (is_match && !found_ff) begin
            found_in   = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!cur_valid && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = cmp_idx_ff;
         end
         // Strict less-than keeps the lowest index on equal stamps.
         if ((cmp_idx_ff == '0) || (stamp_rd_ff < best_stamp_ff)) begin
            best_stamp_in = stamp_rd_ff;
            best_idx_in   = cmp_idx_ff;
            best_page_in  = page_rd_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= FRAME_COUNT_RESET;
         valid_ff     <= '0;
         use_ctr_ff   <= '0;
         fault_ff     <= '0;
         cmp_en_ff    <= 1'b0;
         found_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         valid_ff     <= valid_in;
         use_ctr_ff   <= use_ctr_in;
         fault_ff     <= fault_in;
         cmp_en_ff    <= cmd.issue;
         found_ff     <= found_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      scan_idx_ff   <= scan_idx_in;
      hit_idx_ff    <= hit_idx_in;
      empty_idx_ff  <= empty_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_idx_ff   <= best_idx_in;
      best_page_ff  <= best_page_in;
      if (cmd.issue) begin
         cmp_idx_ff <= scan_idx_ff;
      end
   end

   // Result register; it only loads when empty or being drained.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff      <= found_ff;
         rsp_index_ff    <= pos_ext[FRAME_INDEX_W-1:0];
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= evict ? ev_ext[EVICTED_PAGE_W-1:0] : '0;
         rsp_fault_ff    <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

endmodule
